/* rtl/core/twtt_pkg.sv */
// Shared types and constants of the task timeout timing wheel.
// No dependencies; every other file of the block imports this package.
package twtt_pkg;

	// Wheel geometry: the slot index wraps at a power of two, so the sum of
	// current slot and delay is simply truncated.
	localparam int unsigned SLOTS        = 64;
	localparam int unsigned SLOT_W       = $clog2(SLOTS);
	localparam int unsigned WORKER_W     = 4;
	localparam int unsigned WORKERS_DFLT = 16;
	localparam int unsigned DELAY_W      = 6;
	localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(2);

	// Command codes carried in the item.
	localparam logic [1:0] CMD_ARM    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// Result kinds.
	localparam logic [2:0] RK_ARMED     = 3'd0;
	localparam logic [2:0] RK_CANCELLED = 3'd1;
	localparam logic [2:0] RK_NOTHING   = 3'd2;
	localparam logic [2:0] RK_EXPIRED   = 3'd3;
	localparam logic [2:0] RK_IDLE_TICK = 3'd4;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [WORKER_W-1:0] worker;
		logic                task_kind;
	} item_t;

	typedef struct packed {
		logic [2:0]          result_kind;
		logic [WORKER_W-1:0] out_worker;
		logic                out_task_kind;
		logic                last;
	} result_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic [WORKER_W-1:0] idx;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   cur;
		logic                kind;
		logic                arm_we;
		logic                probe;
		logic                cancel_clr;
		logic                advance;
	} ctl_t;

	// Report rippling along the row: at most one cell contributes.
	typedef struct packed {
		logic hit;
		logic kind;
	} rep_t;

endpackage

/* rtl/core/twtt_cell.sv */
// One timer cell of the wheel: armed flag, target slot and task kind of one worker.
// Depends on twtt_pkg; chained by the top level, one cell per worker.
module twtt_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  twtt_pkg::ctl_t ctl,
	input  logic          tok_i,
	input  twtt_pkg::rep_t rep_i,
	output logic          tok_o,
	output twtt_pkg::rep_t rep_o
);
	import twtt_pkg::*;

	localparam logic [WORKER_W-1:0] MY_IDX = WORKER_W'(IDX);

	logic              armed_q;
	logic              tok_q;
	logic [SLOT_W-1:0] slot_q;
	logic              kind_q;
	logic              sel;
	logic              mine_hit;

	assign sel      = (ctl.idx == MY_IDX);
	assign mine_hit = (ctl.probe & sel & armed_q) | (tok_q & armed_q & (slot_q == ctl.cur));

	assign rep_o.hit  = rep_i.hit | mine_hit;
	assign rep_o.kind = rep_i.kind | (mine_hit & kind_q);
	assign tok_o      = tok_q & ctl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_i | (tok_q & ~ctl.advance);
			if (ctl.arm_we & sel) begin
				armed_q <= 1'b1;
			end else if ((ctl.cancel_clr & sel) | (tok_q & mine_hit & ctl.advance)) begin
				armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.arm_we & sel) begin
			slot_q <= ctl.slot;
			kind_q <= ctl.kind;
		end
	end

endmodule

/* rtl/core/timing_wheel_task_timeouts.sv */
// Task timeout timing wheel: one timer cell per worker, a scan token along the row.
// An arm or cancel result is registered in the exec step once the output register is free,
// and the next item is taken on the return to idle; a tick's last result is registered in
// the finishing step after the token has stepped one cell per cycle along the row, unless
// a hit is held back by output stalls. The next item is accepted while the last result waits.
// Reset (arst_n, asynchronous, active low) clears armed flags, current slot and controller.
module timing_wheel_task_timeouts #(
	parameter int unsigned WORKERS = twtt_pkg::WORKERS_DFLT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  twtt_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output twtt_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [twtt_pkg::DELAY_W-1:0] cfg_data
);
	import twtt_pkg::*;

	// The controller walks through four one-hot states. An item is captured in
	// idle, carried out in exec, and a tick then moves on to the scan of the row
	// and a finishing step that delivers the last result of the tick.
	// The arm delay is loaded with 2 at reset; slot and kind stores are not reset.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [WORKER_W-1:0] scan_idx_q;
	logic                pend_valid_q;
	logic [WORKER_W-1:0] pend_worker_q;
	logic                pend_kind_q;
	logic                res_valid_q;
	result_t             res_q;

	ctl_t    ctl;
	logic    tok_chain [0:WORKERS];
	rep_t    rep_chain [0:WORKERS];
	rep_t    rep;
	logic    scan_done;
	logic    out_free;
	logic    in_range;
	logic    advance;
	logic    res_load;
	result_t res_d;

	// The output register is free when it is empty or its beat leaves now.
	assign out_free   = ~res_valid_q | ~result_stall;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign in_range = ({1'b0, item_q.worker} < (WORKER_W + 1)'(WORKERS));

	// During the scan the token may only move on when a hit has somewhere to go:
	// the pending slot is empty, or the pending result can move to the output.
	assign advance = ~rep.hit | ~pend_valid_q | out_free;

	always_comb begin
		ctl            = '0;
		ctl.idx        = item_q.worker;
		ctl.slot       = cur_q + SLOT_W'(delay_q);
		ctl.cur        = cur_q;
		ctl.kind       = item_q.task_kind;
		ctl.arm_we     = (state_q == S_EXEC) & (item_q.cmd == CMD_ARM) & in_range & out_free;
		ctl.probe      = (state_q == S_EXEC) & (item_q.cmd == CMD_CANCEL) & in_range;
		ctl.cancel_clr = ctl.probe & out_free;
		ctl.advance    = (state_q == S_SCAN) & advance;
	end

	// The token enters the first cell in the cycle after the tick is executed,
	// when the current slot already holds its new value.
	assign tok_chain[0] = (state_q == S_EXEC) & (item_q.cmd == CMD_TICK);
	assign rep_chain[0] = '0;

	for (genvar g = 0; g < WORKERS; g++) begin : g_cell
		twtt_cell #(
			.IDX(g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.tok_i (tok_chain[g]),
			.rep_i (rep_chain[g]),
			.tok_o (tok_chain[g+1]),
			.rep_o (rep_chain[g+1])
		);
	end

	assign rep       = rep_chain[WORKERS];
	assign scan_done = tok_chain[WORKERS];

	// Result selection. Expired timers are held back by one in the pending
	// register, so that the final one can carry the last mark at the end of the scan.
	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			S_EXEC: begin
				res_d.out_worker = item_q.worker;
				res_d.last       = 1'b1;
				if ((item_q.cmd == CMD_ARM) || (item_q.cmd == CMD_CANCEL)) begin
					res_load = out_free;
					if (!in_range) begin
						res_d.result_kind = RK_NOTHING;
					end else if (item_q.cmd == CMD_ARM) begin
						res_d.result_kind   = RK_ARMED;
						res_d.out_task_kind = item_q.task_kind;
					end else if (rep.hit) begin
						res_d.result_kind   = RK_CANCELLED;
						res_d.out_task_kind = rep.kind;
					end else begin
						res_d.result_kind = RK_NOTHING;
					end
				end
			end
			S_SCAN: begin
				res_load            = rep.hit & pend_valid_q & out_free;
				res_d.result_kind   = RK_EXPIRED;
				res_d.out_worker    = pend_worker_q;
				res_d.out_task_kind = pend_kind_q;
			end
			S_FINISH: begin
				res_load   = out_free;
				res_d.last = 1'b1;
				if (pend_valid_q) begin
					res_d.result_kind   = RK_EXPIRED;
					res_d.out_worker    = pend_worker_q;
					res_d.out_task_kind = pend_kind_q;
				end else begin
					res_d.result_kind = RK_IDLE_TICK;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			delay_q      <= DELAY_RST;
			scan_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				delay_q <= cfg_data;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.cmd)
						CMD_ARM, CMD_CANCEL: begin
							if (out_free) begin
								state_q <= S_IDLE;
							end
						end
						CMD_TICK: begin
							cur_q        <= cur_q + SLOT_W'(1);
							scan_idx_q   <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= S_SCAN;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SCAN: begin
					if (advance) begin
						scan_idx_q <= scan_idx_q + WORKER_W'(1);
						if (rep.hit) begin
							pend_valid_q <= 1'b1;
						end
						if (scan_done) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the captured item, the pending expiry and the result.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item_valid) begin
			item_q <= item;
		end
		if ((state_q == S_SCAN) && advance && rep.hit) begin
			pend_worker_q <= scan_idx_q;
			pend_kind_q   <= rep.kind;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

/* rtl/core/twtt_checker.sv */
// Port-level checks of the task timeout timing wheel, bound to the top level.
// Depends on twtt_pkg and on the port list of timing_wheel_task_timeouts.
module twtt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input twtt_pkg::result_t result
);
	import twtt_pkg::*;

	// A result beat held back by the receiver stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// Items are worked on one at a time: the cycle after a beat is taken, input stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted in the cycle after another");

	// A tick with no expiry is a single result, for worker zero.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == RK_IDLE_TICK) |->
		result.last && (result.out_worker == '0) && !result.out_task_kind)
		else $error("malformed no-expiry result");

	// Arm and cancel produce exactly one result, so it always carries the last mark.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((result.result_kind == RK_ARMED) ||
		(result.result_kind == RK_CANCELLED) || (result.result_kind == RK_NOTHING))
		|-> result.last)
		else $error("single-result item without last mark");

endmodule

bind timing_wheel_task_timeouts twtt_checker u_twtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
